// ===== sv/assert_macros.svh =====
// Assertion macros shared by the controller and the datapath.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/baoab_pkg.sv =====
// Shared widths, register codes, command encodings and types for the BAOAB oscillator step.
// No dependencies; every module of the block imports this package.
package baoab_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int NOISE_WIDTH   = 16;
    localparam int NOISE_FRAC    = 12;
    localparam int COEF_WIDTH    = 31;
    localparam int DAMP_WIDTH    = 17;
    localparam int ENERGY_WIDTH  = DATA_WIDTH - 1;
    localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
    localparam int XSQ_WIDTH     = 2 * DATA_WIDTH - FRAC_BITS;
    localparam int ACC_WIDTH     = COEF_WIDTH + XSQ_WIDTH + 1;
    localparam int APB_WIDTH     = 32;
    localparam int ADDR_WIDTH    = 5;
    localparam int REG_IDX_WIDTH = ADDR_WIDTH - 2;

    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [REG_IDX_WIDTH-1:0] IDX_HALF_STEP      = REG_IDX_WIDTH'(0);
    localparam logic [REG_IDX_WIDTH-1:0] IDX_HALF_STEP_MASS = REG_IDX_WIDTH'(1);
    localparam logic [REG_IDX_WIDTH-1:0] IDX_SPRING         = REG_IDX_WIDTH'(2);
    localparam logic [REG_IDX_WIDTH-1:0] IDX_DAMPING        = REG_IDX_WIDTH'(3);
    localparam logic [REG_IDX_WIDTH-1:0] IDX_NOISE_SCALE    = REG_IDX_WIDTH'(4);

    localparam logic [COEF_WIDTH-1:0] RST_HALF_STEP      = COEF_WIDTH'(32768);
    localparam logic [COEF_WIDTH-1:0] RST_HALF_STEP_MASS = COEF_WIDTH'(32768);
    localparam logic [COEF_WIDTH-1:0] RST_SPRING         = COEF_WIDTH'(65536);
    localparam logic [DAMP_WIDTH-1:0] RST_DAMPING        = DAMP_WIDTH'(24109);
    localparam logic [COEF_WIDTH-1:0] RST_NOISE_SCALE    = COEF_WIDTH'(60596);

    typedef struct packed {
        logic [COEF_WIDTH-1:0] half_step;
        logic [COEF_WIDTH-1:0] half_step_over_mass;
        logic [COEF_WIDTH-1:0] spring_constant;
        logic [DAMP_WIDTH-1:0] damping_factor;
        logic [COEF_WIDTH-1:0] noise_scale;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KICK_A,
        ST_KICK_W,
        ST_DRIFT_A,
        ST_DRIFT_W,
        ST_OU_NOISE,
        ST_OU_ADD,
        ST_DRIFT2_A,
        ST_DRIFT2_W,
        ST_FORCE_A,
        ST_FORCE_W,
        ST_KICK2_A,
        ST_KICK2_W,
        ST_ENERGY_HI,
        ST_ENERGY_W
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_HS_F,
        MUL_HSM_P,
        MUL_DF_P,
        MUL_NS_N,
        MUL_K_X,
        MUL_X_X,
        MUL_K_XSQ_LO,
        MUL_K_XSQ_HI
    } mul_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_P_ADD,
        WR_X_ADD,
        WR_P_SET,
        WR_F_NEG,
        WR_XSQ,
        WR_ACC_LO,
        WR_ENERGY
    } post_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        post_op_t post_op;
        logic     take_noise;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/baoab_regs.sv =====
// APB register file holding the five step coefficients.
// Depends on baoab_pkg for widths, register indexes and reset values.
module baoab_regs
    import baoab_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [APB_WIDTH-1:0]  pwdata,
    output logic [APB_WIDTH-1:0]  prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [COEF_WIDTH-1:0]    half_step_reg;
    logic [COEF_WIDTH-1:0]    half_step_mass_reg;
    logic [COEF_WIDTH-1:0]    spring_reg;
    logic [DAMP_WIDTH-1:0]    damping_reg;
    logic [COEF_WIDTH-1:0]    noise_scale_reg;
    logic [REG_IDX_WIDTH-1:0] idx;
    logic                     wr_en;

    assign idx    = paddr[ADDR_WIDTH-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_step_reg      <= RST_HALF_STEP;
            half_step_mass_reg <= RST_HALF_STEP_MASS;
            spring_reg         <= RST_SPRING;
            damping_reg        <= RST_DAMPING;
            noise_scale_reg    <= RST_NOISE_SCALE;
        end else if (wr_en) begin
            unique case (idx)
                IDX_HALF_STEP:      half_step_reg      <= pwdata[COEF_WIDTH-1:0];
                IDX_HALF_STEP_MASS: half_step_mass_reg <= pwdata[COEF_WIDTH-1:0];
                IDX_SPRING:         spring_reg         <= pwdata[COEF_WIDTH-1:0];
                IDX_DAMPING:        damping_reg        <= pwdata[DAMP_WIDTH-1:0];
                IDX_NOISE_SCALE:    noise_scale_reg    <= pwdata[COEF_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            IDX_HALF_STEP:      prdata = APB_WIDTH'(half_step_reg);
            IDX_HALF_STEP_MASS: prdata = APB_WIDTH'(half_step_mass_reg);
            IDX_SPRING:         prdata = APB_WIDTH'(spring_reg);
            IDX_DAMPING:        prdata = APB_WIDTH'(damping_reg);
            IDX_NOISE_SCALE:    prdata = APB_WIDTH'(noise_scale_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.half_step           = half_step_reg;
    assign cfg.half_step_over_mass = half_step_mass_reg;
    assign cfg.spring_constant     = spring_reg;
    assign cfg.damping_factor      = damping_reg;
    assign cfg.noise_scale         = noise_scale_reg;

endmodule

// ===== sv/baoab_ctrl.sv =====
// Sequencer that steps the shared multiplier and write-back stage through one BAOAB step.
// Depends on baoab_pkg for the state, command and status types, and on assert_macros.svh.
`include "assert_macros.svh"

module baoab_ctrl
    import baoab_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.mul_sel    = MUL_NONE;
        cmd.post_op    = WR_NONE;
        cmd.take_noise = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.take_noise = s_valid;
                if (s_valid) begin
                    state_next = ST_KICK_A;
                end
            end
            ST_KICK_A: begin
                cmd.mul_sel = MUL_HS_F;
                state_next  = ST_KICK_W;
            end
            ST_KICK_W: begin
                cmd.post_op = WR_P_ADD;
                state_next  = ST_DRIFT_A;
            end
            ST_DRIFT_A: begin
                cmd.mul_sel = MUL_HSM_P;
                state_next  = ST_DRIFT_W;
            end
            ST_DRIFT_W: begin
                cmd.mul_sel = MUL_DF_P;
                cmd.post_op = WR_X_ADD;
                state_next  = ST_OU_NOISE;
            end
            ST_OU_NOISE: begin
                cmd.mul_sel = MUL_NS_N;
                cmd.post_op = WR_P_SET;
                state_next  = ST_OU_ADD;
            end
            ST_OU_ADD: begin
                cmd.post_op = WR_P_ADD;
                state_next  = ST_DRIFT2_A;
            end
            ST_DRIFT2_A: begin
                cmd.mul_sel = MUL_HSM_P;
                state_next  = ST_DRIFT2_W;
            end
            ST_DRIFT2_W: begin
                cmd.post_op = WR_X_ADD;
                state_next  = ST_FORCE_A;
            end
            ST_FORCE_A: begin
                cmd.mul_sel = MUL_K_X;
                state_next  = ST_FORCE_W;
            end
            ST_FORCE_W: begin
                cmd.mul_sel = MUL_X_X;
                cmd.post_op = WR_F_NEG;
                state_next  = ST_KICK2_A;
            end
            ST_KICK2_A: begin
                cmd.mul_sel = MUL_HS_F;
                cmd.post_op = WR_XSQ;
                state_next  = ST_KICK2_W;
            end
            ST_KICK2_W: begin
                cmd.mul_sel = MUL_K_XSQ_LO;
                cmd.post_op = WR_P_ADD;
                state_next  = ST_ENERGY_HI;
            end
            ST_ENERGY_HI: begin
                cmd.mul_sel = MUL_K_XSQ_HI;
                cmd.post_op = WR_ACC_LO;
                state_next  = ST_ENERGY_W;
            end
            ST_ENERGY_W: begin
                if (!stat.out_busy) begin
                    cmd.post_op = WR_ENERGY;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts_step, s_valid && s_ready, state_reg == ST_KICK_A, "accepted word did not start a step")
    `ASSERT_RST(a_idle_quiet, state_reg == ST_IDLE |-> cmd.mul_sel == MUL_NONE && cmd.post_op == WR_NONE, "datapath commanded while idle")
    `ASSERT_NEXT(a_stall_holds, state_reg == ST_ENERGY_W && stat.out_busy, state_reg == ST_ENERGY_W && !s_ready, "step left while result still pending")

endmodule

// ===== sv/baoab_dp.sv =====
// Datapath: state registers, shared 32x32 multiplier, rounding, saturation and result register.
// Depends on baoab_pkg for widths, saturation limits and the command and status types.
`include "assert_macros.svh"

module baoab_dp
    import baoab_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cfg_t                           cfg,
    input  cmd_t                           cmd,
    output stat_t                          stat,
    input  logic signed [NOISE_WIDTH-1:0]  s_noise_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]   m_new_position,
    output logic signed [DATA_WIDTH-1:0]   m_new_momentum,
    output logic signed [DATA_WIDTH-1:0]   m_new_force,
    output logic        [ENERGY_WIDTH-1:0] m_potential_energy
);

    localparam logic [PROD_WIDTH:0] RND_FRAC  = (PROD_WIDTH+1)'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_WIDTH:0] RND_NOISE = (PROD_WIDTH+1)'(1) << (NOISE_FRAC - 1);
    localparam logic [ACC_WIDTH-1:0] RND_ENERGY = ACC_WIDTH'(1) << FRAC_BITS;

    function automatic logic [DATA_WIDTH-1:0] mag_f(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] sadd_f(input logic [DATA_WIDTH-1:0] a,
                                                     input logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] sneg_f(input logic [DATA_WIDTH-1:0] v);
        return (v == VMIN) ? VMAX : (~v + DATA_WIDTH'(1));
    endfunction

    logic [DATA_WIDTH-1:0]   pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]   mom_reg, mom_next;
    logic [DATA_WIDTH-1:0]   force_reg, force_next;
    logic [NOISE_WIDTH-1:0]  noise_reg;
    logic [PROD_WIDTH-1:0]   prod_reg;
    logic                    prod_neg_reg;
    logic                    prod_noise_reg;
    logic [XSQ_WIDTH-1:0]    xsq_reg, xsq_next;
    logic [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]   out_pos_reg, out_mom_reg, out_force_reg;
    logic [ENERGY_WIDTH-1:0] out_energy_reg;
    logic                    m_valid_reg, m_valid_next;

    logic [DATA_WIDTH-1:0]   op_a, op_b;
    logic                    op_neg, op_noise;
    logic [DATA_WIDTH-1:0]   noise_ext;
    logic [PROD_WIDTH:0]     round_sum, rounded, cap_ext;
    logic [DATA_WIDTH-1:0]   mag_cap, sat_mag, term;
    logic [ACC_WIDTH-1:0]    energy_sum, energy_q;
    logic [ENERGY_WIDTH-1:0] energy_sat;
    logic                    load_out;

    assign noise_ext = DATA_WIDTH'($signed(noise_reg));

    always_comb begin
        op_a     = '0;
        op_b     = '0;
        op_neg   = 1'b0;
        op_noise = 1'b0;
        unique case (cmd.mul_sel)
            MUL_HS_F: begin
                op_a   = DATA_WIDTH'(cfg.half_step);
                op_b   = mag_f(force_reg);
                op_neg = force_reg[DATA_WIDTH-1];
            end
            MUL_HSM_P: begin
                op_a   = DATA_WIDTH'(cfg.half_step_over_mass);
                op_b   = mag_f(mom_reg);
                op_neg = mom_reg[DATA_WIDTH-1];
            end
            MUL_DF_P: begin
                op_a   = DATA_WIDTH'(cfg.damping_factor);
                op_b   = mag_f(mom_reg);
                op_neg = mom_reg[DATA_WIDTH-1];
            end
            MUL_NS_N: begin
                op_a     = DATA_WIDTH'(cfg.noise_scale);
                op_b     = mag_f(noise_ext);
                op_neg   = noise_ext[DATA_WIDTH-1];
                op_noise = 1'b1;
            end
            MUL_K_X: begin
                op_a   = DATA_WIDTH'(cfg.spring_constant);
                op_b   = mag_f(pos_reg);
                op_neg = pos_reg[DATA_WIDTH-1];
            end
            MUL_X_X: begin
                op_a = mag_f(pos_reg);
                op_b = mag_f(pos_reg);
            end
            MUL_K_XSQ_LO: begin
                op_a = DATA_WIDTH'(cfg.spring_constant);
                op_b = xsq_reg[DATA_WIDTH-1:0];
            end
            MUL_K_XSQ_HI: begin
                op_a = DATA_WIDTH'(cfg.spring_constant);
                op_b = DATA_WIDTH'(xsq_reg[XSQ_WIDTH-1:DATA_WIDTH]);
            end
            default: begin
            end
        endcase
    end

    // Round to nearest with ties away from zero on the magnitude, then clamp.
    always_comb begin
        round_sum = {1'b0, prod_reg} + (prod_noise_reg ? RND_NOISE : RND_FRAC);
        rounded   = prod_noise_reg ? (round_sum >> NOISE_FRAC) : (round_sum >> FRAC_BITS);
        mag_cap   = prod_neg_reg ? VMIN : VMAX;
        cap_ext   = (PROD_WIDTH+1)'(mag_cap);
        sat_mag   = (rounded > cap_ext) ? mag_cap : rounded[DATA_WIDTH-1:0];
        term      = prod_neg_reg ? (~sat_mag + DATA_WIDTH'(1)) : sat_mag;
    end

    always_comb begin
        energy_sum = acc_reg + (ACC_WIDTH'(prod_reg) << DATA_WIDTH);
        energy_q   = energy_sum >> (FRAC_BITS + 1);
        energy_sat = (|energy_q[ACC_WIDTH-1:ENERGY_WIDTH]) ? '1 : energy_q[ENERGY_WIDTH-1:0];
    end

    always_comb begin
        pos_next   = pos_reg;
        mom_next   = mom_reg;
        force_next = force_reg;
        xsq_next   = xsq_reg;
        acc_next   = acc_reg;
        load_out   = 1'b0;
        unique case (cmd.post_op)
            WR_NONE: begin
            end
            WR_P_ADD:  mom_next   = sadd_f(mom_reg, term);
            WR_X_ADD:  pos_next   = sadd_f(pos_reg, term);
            WR_P_SET:  mom_next   = term;
            WR_F_NEG:  force_next = sneg_f(term);
            WR_XSQ:    xsq_next   = rounded[XSQ_WIDTH-1:0];
            WR_ACC_LO: acc_next   = ACC_WIDTH'(prod_reg) + RND_ENERGY;
            WR_ENERGY: load_out   = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            mom_reg     <= '0;
            force_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            mom_reg     <= mom_next;
            force_reg   <= force_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_noise) begin
            noise_reg <= s_noise_sample;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg       <= PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);
            prod_neg_reg   <= op_neg;
            prod_noise_reg <= op_noise;
        end
        xsq_reg <= xsq_next;
        acc_reg <= acc_next;
        if (load_out) begin
            out_pos_reg    <= pos_reg;
            out_mom_reg    <= mom_reg;
            out_force_reg  <= force_reg;
            out_energy_reg <= energy_sat;
        end
    end

    assign stat.out_busy      = m_valid_reg && !m_ready;
    assign m_valid            = m_valid_reg;
    assign m_new_position     = $signed(out_pos_reg);
    assign m_new_momentum     = $signed(out_mom_reg);
    assign m_new_force        = $signed(out_force_reg);
    assign m_potential_energy = out_energy_reg;

    `ASSERT_RST(a_post_after_mul, cmd.post_op != WR_NONE && cmd.post_op != WR_ENERGY |-> $past(cmd.mul_sel) != MUL_NONE, "write-back without a product")
    `ASSERT_RST(a_no_overwrite, load_out |-> !(m_valid_reg && !m_ready), "result register overwritten while pending")
    `ASSERT_NEXT(a_load_shows, load_out, m_valid_reg && m_potential_energy == $past(energy_sat), "loaded result not presented")

endmodule

// ===== sv/baoab_langevin_oscillator_step.sv =====
// Top level of the BAOAB Langevin step for one harmonic oscillator.
// Depends on baoab_pkg, baoab_regs, baoab_ctrl and baoab_dp.
//
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   s_noise_sample
// m_       out  m_valid / m_ready   m_new_position, m_new_momentum, m_new_force,
//                                   m_potential_energy
// APB      in   psel, penable       paddr, pwdata, pwrite -> prdata, pready
//
// Each word passes through 14 controller steps from acceptance to the loaded result, then the
// idle state, the only one that takes a word; every product uses the single shared 32 by 32 multiplier.
// Reset is synchronous; it clears position, momentum and force and restores the coefficients.
// A result waits in the output register while the next word is accepted and worked on.
// If that earlier result is still not taken, the controller holds in its final step.
module baoab_langevin_oscillator_step
    import baoab_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_WIDTH-1:0]          paddr,
    input  logic [APB_WIDTH-1:0]           pwdata,
    output logic [APB_WIDTH-1:0]           prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [NOISE_WIDTH-1:0]  s_noise_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]   m_new_position,
    output logic signed [DATA_WIDTH-1:0]   m_new_momentum,
    output logic signed [DATA_WIDTH-1:0]   m_new_force,
    output logic        [ENERGY_WIDTH-1:0] m_potential_energy
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    baoab_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    baoab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    baoab_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .cmd                (cmd),
        .stat               (stat),
        .s_noise_sample     (s_noise_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_position     (m_new_position),
        .m_new_momentum     (m_new_momentum),
        .m_new_force        (m_new_force),
        .m_potential_energy (m_potential_energy)
    );

endmodule
